/* design/lbmcol_pkg.sv */
// Shared types, constants and helpers for the D3Q15 BGK collision core.
// Holds the direction table, saturating add/sub and the divide-by-nine constant.
// No dependencies.
package lbmcol_pkg;

  localparam int IW      = 64;
  localparam int HW      = IW / 2;
  localparam int MUL_LAT = 5;
  localparam int DIV_LAT = 3;

  typedef logic signed [IW-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(IW-1){1'b0}}};

  // ceil(2^67 / 9): exact floor(x / 9) for any 64-bit x
  localparam logic [IW-1:0] DIV9_RECIP = 64'hE38E38E38E38E38F;
  localparam int            DIV9_SHIFT = 67;

  localparam logic [1:0] COMP_ZERO = 2'd0;
  localparam logic [1:0] COMP_POS  = 2'd1;
  localparam logic [1:0] COMP_NEG  = 2'd2;

  localparam logic [1:0] CLS_REST = 2'd0;
  localparam logic [1:0] CLS_AXIS = 2'd1;
  localparam logic [1:0] CLS_DIAG = 2'd2;
  localparam logic [1:0] CLS_NONE = 2'd3;

  localparam logic [3:0] DIR_REST = 4'd0;
  localparam logic [3:0] DIR_PX   = 4'd1;
  localparam logic [3:0] DIR_NX   = 4'd2;
  localparam logic [3:0] DIR_PY   = 4'd3;
  localparam logic [3:0] DIR_NY   = 4'd4;
  localparam logic [3:0] DIR_PZ   = 4'd5;
  localparam logic [3:0] DIR_NZ   = 4'd6;
  localparam logic [3:0] DIR_PPP  = 4'd7;
  localparam logic [3:0] DIR_NNN  = 4'd8;
  localparam logic [3:0] DIR_PPN  = 4'd9;
  localparam logic [3:0] DIR_NNP  = 4'd10;
  localparam logic [3:0] DIR_PNP  = 4'd11;
  localparam logic [3:0] DIR_NPN  = 4'd12;
  localparam logic [3:0] DIR_NPP  = 4'd13;
  localparam logic [3:0] DIR_PNN  = 4'd14;
  localparam logic [3:0] DIR_NONE = 4'd15;

  localparam logic [1:0] REG_RELAX    = 2'd0;
  localparam logic [1:0] REG_INV_CS2  = 2'd1;
  localparam logic [1:0] REG_INV_2CS4 = 2'd2;

  typedef struct packed {
    logic [1:0] ex;
    logic [1:0] ey;
    logic [1:0] ez;
    logic [1:0] cls;
  } dir_info_t;

  function automatic dir_info_t dir_info(input logic [3:0] d);
    dir_info_t i;
    unique case (d)
      DIR_REST: i = '{COMP_ZERO, COMP_ZERO, COMP_ZERO, CLS_REST};
      DIR_PX:   i = '{COMP_POS,  COMP_ZERO, COMP_ZERO, CLS_AXIS};
      DIR_NX:   i = '{COMP_NEG,  COMP_ZERO, COMP_ZERO, CLS_AXIS};
      DIR_PY:   i = '{COMP_ZERO, COMP_POS,  COMP_ZERO, CLS_AXIS};
      DIR_NY:   i = '{COMP_ZERO, COMP_NEG,  COMP_ZERO, CLS_AXIS};
      DIR_PZ:   i = '{COMP_ZERO, COMP_ZERO, COMP_POS,  CLS_AXIS};
      DIR_NZ:   i = '{COMP_ZERO, COMP_ZERO, COMP_NEG,  CLS_AXIS};
      DIR_PPP:  i = '{COMP_POS,  COMP_POS,  COMP_POS,  CLS_DIAG};
      DIR_NNN:  i = '{COMP_NEG,  COMP_NEG,  COMP_NEG,  CLS_DIAG};
      DIR_PPN:  i = '{COMP_POS,  COMP_POS,  COMP_NEG,  CLS_DIAG};
      DIR_NNP:  i = '{COMP_NEG,  COMP_NEG,  COMP_POS,  CLS_DIAG};
      DIR_PNP:  i = '{COMP_POS,  COMP_NEG,  COMP_POS,  CLS_DIAG};
      DIR_NPN:  i = '{COMP_NEG,  COMP_POS,  COMP_NEG,  CLS_DIAG};
      DIR_NPP:  i = '{COMP_NEG,  COMP_POS,  COMP_POS,  CLS_DIAG};
      DIR_PNN:  i = '{COMP_POS,  COMP_NEG,  COMP_NEG,  CLS_DIAG};
      DIR_NONE: i = '{COMP_ZERO, COMP_ZERO, COMP_ZERO, CLS_NONE};
    endcase
    return i;
  endfunction

  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    logic [IW:0] s;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) return s[IW] ? ACC_MIN : ACC_MAX;
    return acc_t'(s[IW-1:0]);
  endfunction

  function automatic acc_t sat_sub(input acc_t a, input acc_t b);
    logic [IW:0] s;
    s = {a[IW-1], a} - {b[IW-1], b};
    if (s[IW] != s[IW-1]) return s[IW] ? ACC_MIN : ACC_MAX;
    return acc_t'(s[IW-1:0]);
  endfunction

  function automatic acc_t add_comp(input acc_t acc, input logic [1:0] c, input acc_t u);
    acc_t r;
    unique case (c)
      COMP_POS: r = sat_add(acc, u);
      COMP_NEG: r = sat_sub(acc, u);
      default:  r = acc;
    endcase
    return r;
  endfunction

endpackage

/* design/lbmcol_mulsh.sv */
// Pipelined signed 64x64 multiply, scaled by 2^-SHIFT, round half away, saturate.
// Five register stages, built from four 32x32 partial products.
// Depends on lbmcol_pkg.
module lbmcol_mulsh
  import lbmcol_pkg::*;
#(
  parameter int SHIFT = 28
) (
  input  logic clk,
  input  acc_t a,
  input  acc_t b,
  output acc_t p
);

  localparam logic [2*IW-1:0] RND = (2*IW)'(1) << (SHIFT - 1);

  logic            neg1, neg2, neg3, neg4;
  logic [IW-1:0]   ua, ub;
  logic [IW-1:0]   pp00, pp01, pp10, pp11;
  logic [2*IW-1:0] prod, shifted;

  always_ff @(posedge clk) begin
    neg1 <= a[IW-1] ^ b[IW-1];
    ua   <= a[IW-1] ? IW'(-a) : IW'(a);
    ub   <= b[IW-1] ? IW'(-b) : IW'(b);

    neg2 <= neg1;
    pp00 <= ua[HW-1:0]  * ub[HW-1:0];
    pp01 <= ua[HW-1:0]  * ub[IW-1:HW];
    pp10 <= ua[IW-1:HW] * ub[HW-1:0];
    pp11 <= ua[IW-1:HW] * ub[IW-1:HW];

    neg3 <= neg2;
    prod <= {pp11, pp00} + {{HW{1'b0}}, pp01, {HW{1'b0}}}
                         + {{HW{1'b0}}, pp10, {HW{1'b0}}};

    neg4    <= neg3;
    shifted <= (prod + RND) >> SHIFT;

    if (neg4) begin
      if (shifted[2*IW-1:IW] != '0 || shifted[IW-1:0] > IW'(ACC_MIN)) p <= ACC_MIN;
      else p <= acc_t'(-shifted[IW-1:0]);
    end else begin
      if (shifted[2*IW-1:IW] != '0 || shifted[IW-1]) p <= ACC_MAX;
      else p <= acc_t'(shifted[IW-1:0]);
    end
  end

endmodule

/* design/lbmcol_div9.sv */
// Pipelined unsigned divide by nine: quotient and remainder of a 64-bit value.
// Reciprocal multiply in three register stages.
// Depends on lbmcol_pkg.
module lbmcol_div9
  import lbmcol_pkg::*;
(
  input  logic          clk,
  input  logic [IW-1:0] x,
  output logic [IW-1:0] q,
  output logic [3:0]    rem
);

  logic [IW-1:0] pp00, pp01, pp10, pp11;
  logic [IW-1:0] q2;
  logic [3:0]    x_lo1, x_lo2;

  always_ff @(posedge clk) begin
    pp00  <= x[HW-1:0]  * DIV9_RECIP[HW-1:0];
    pp01  <= x[HW-1:0]  * DIV9_RECIP[IW-1:HW];
    pp10  <= x[IW-1:HW] * DIV9_RECIP[HW-1:0];
    pp11  <= x[IW-1:HW] * DIV9_RECIP[IW-1:HW];
    x_lo1 <= x[3:0];

    q2    <= IW'(({pp11, pp00} + {{HW{1'b0}}, pp01, {HW{1'b0}}}
                               + {{HW{1'b0}}, pp10, {HW{1'b0}}}) >> DIV9_SHIFT);
    x_lo2 <= x_lo1;

    // remainder < 9, so four low bits of x - 9q are enough
    q   <= q2;
    rem <= x_lo2 - q2[3:0] - {q2[0], 3'b000};
  end

endmodule

/* design/lbm_d3q15_bgk_collision_core.sv */
// D3Q15 lattice Boltzmann BGK collision for one distribution value per request.
// Top level; uses lbmcol_pkg, lbmcol_mulsh and lbmcol_div9.
//
//   channel   ports                                             handshake
//   request   cell_density vel_x vel_y vel_z direction dist_in  start / busy
//   result    dist_out out_direction                            done (one cycle)
//   config    wr_index wr_data                                  wr_en
//
// One request per clock, every clock; busy stays low. Each result passes through
// three dependent five-stage multipliers (eu*eu*B, rho*r*poly) and then the
// divide-by-nine stages.
// rst is synchronous: it drops in-flight requests and restores the registers.
// The receiver cannot stall; the pipeline never holds.
module lbm_d3q15_bgk_collision_core
  import lbmcol_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] cell_density,
  input  logic signed [VALUE_WIDTH-1:0] vel_x,
  input  logic signed [VALUE_WIDTH-1:0] vel_y,
  input  logic signed [VALUE_WIDTH-1:0] vel_z,
  input  logic [3:0]                    direction,
  input  logic signed [VALUE_WIDTH-1:0] dist_in,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [VALUE_WIDTH-2:0]        wr_data,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] dist_out,
  output logic [3:0]                    out_direction
);

  localparam int RW = VALUE_WIDTH - 1;

  localparam logic [IW-1:0] ONE_U  = IW'(1) << FRAC_BITS;
  localparam acc_t          ONE_S  = acc_t'(ONE_U);
  localparam logic [IW-1:0] RMASK  = (IW'(1) << RW) - IW'(1);
  localparam logic [IW-1:0] R_RST  = ONE_U & RMASK;
  localparam logic [IW-1:0] CA_RST = (ONE_U * 3) & RMASK;
  localparam logic [IW-1:0] CB_RST = ((ONE_U * 9) >> 1) & RMASK;

  localparam logic signed [IW:0] OUT_MAX = $signed({1'b0, RMASK});
  localparam logic signed [IW:0] OUT_MIN = ~OUT_MAX;

  // stage numbers count cycles after the request is taken
  localparam int S_IN   = 1;
  localparam int S_EU   = S_IN + 2;
  localparam int S_SQ   = S_IN + MUL_LAT;
  localparam int S_RR   = S_IN + MUL_LAT;
  localparam int S_USQ  = S_SQ + 2;
  localparam int S_EE   = S_EU + MUL_LAT;
  localparam int S_P1   = S_EE + 1;
  localparam int S_UA   = S_USQ + MUL_LAT;
  localparam int S_POLY = S_UA + 2;
  localparam int S_G    = S_POLY + MUL_LAT;
  localparam int S_W1   = S_G + 1;
  localparam int S_Q    = S_W1 + DIV_LAT;
  localparam int S_MAG  = S_Q + 1;
  localparam int S_OUT  = S_MAG + 1;

  localparam int P1_DLY = S_UA - S_P1;
  localparam int RR_DLY = S_POLY - S_RR;
  localparam int FT_DLY = S_MAG - S_RR;

  // configuration
  logic [RW-1:0] relax_rate, inv_cs2, inv_2cs4;
  acc_t          one_minus_r;
  acc_t          r_ext, ca_ext, cb_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate  <= R_RST[RW-1:0];
      inv_cs2     <= CA_RST[RW-1:0];
      inv_2cs4    <= CB_RST[RW-1:0];
      one_minus_r <= acc_t'(ONE_U - R_RST);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RELAX: begin
          relax_rate  <= wr_data;
          one_minus_r <= acc_t'(ONE_U - IW'(wr_data));
        end
        REG_INV_CS2:  inv_cs2  <= wr_data;
        REG_INV_2CS4: inv_2cs4 <= wr_data;
        default: ;
      endcase
    end
  end

  assign r_ext  = acc_t'(IW'(relax_rate));
  assign ca_ext = acc_t'(IW'(inv_cs2));
  assign cb_ext = acc_t'(IW'(inv_2cs4));

  assign busy = 1'b0;

  // valid and direction travel with the data
  logic [S_OUT:1] vld;
  logic [3:0]     d_pipe [S_IN:S_MAG];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[S_OUT-1:1], start & ~busy};
  end

  always_ff @(posedge clk) begin
    d_pipe[S_IN] <= direction;
    for (int k = S_IN + 1; k <= S_MAG; k++) d_pipe[k] <= d_pipe[k-1];
  end

  assign done = vld[S_OUT];

  // request capture and e.u
  acc_t      rho1, ux1, uy1, uz1, f1;
  acc_t      eu_xy, uz2, eu3;
  dir_info_t info1, info2, info_g, info_q;

  assign info1  = dir_info(d_pipe[S_IN]);
  assign info2  = dir_info(d_pipe[S_IN+1]);
  assign info_g = dir_info(d_pipe[S_G]);
  assign info_q = dir_info(d_pipe[S_Q]);

  always_ff @(posedge clk) begin
    rho1  <= IW'(cell_density);
    ux1   <= IW'(vel_x);
    uy1   <= IW'(vel_y);
    uz1   <= IW'(vel_z);
    f1    <= IW'(dist_in);
    eu_xy <= add_comp(add_comp('0, info1.ex, ux1), info1.ey, uy1);
    uz2   <= uz1;
    eu3   <= add_comp(eu_xy, info2.ez, uz2);
  end

  // products
  acc_t xx, yy, zz, rr, ft, ea, ee, eeb, ua, g;
  acc_t usq1, zz7, usq, p1, p2, ua14, poly;

  // delay lines
  acc_t p1_dly [P1_DLY];
  acc_t rr_dly [RR_DLY];
  acc_t ft_dly [FT_DLY];

  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_xx (.clk(clk), .a(ux1), .b(ux1), .p(xx));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_yy (.clk(clk), .a(uy1), .b(uy1), .p(yy));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_zz (.clk(clk), .a(uz1), .b(uz1), .p(zz));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_rr (.clk(clk), .a(rho1), .b(r_ext), .p(rr));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_ft (.clk(clk), .a(one_minus_r), .b(f1), .p(ft));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_ea (.clk(clk), .a(eu3), .b(ca_ext), .p(ea));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_ee (.clk(clk), .a(eu3), .b(eu3), .p(ee));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_eeb (.clk(clk), .a(ee), .b(cb_ext), .p(eeb));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS + 1)) u_mul_ua (.clk(clk), .a(usq), .b(ca_ext), .p(ua));
  lbmcol_mulsh #(.SHIFT(FRAC_BITS)) u_mul_g (.clk(clk), .a(rr_dly[RR_DLY-1]), .b(poly),
                                             .p(g));

  always_ff @(posedge clk) begin
    p1_dly[0] <= p1;
    for (int k = 1; k < P1_DLY; k++) p1_dly[k] <= p1_dly[k-1];
    rr_dly[0] <= rr;
    for (int k = 1; k < RR_DLY; k++) rr_dly[k] <= rr_dly[k-1];
    ft_dly[0] <= ft;
    for (int k = 1; k < FT_DLY; k++) ft_dly[k] <= ft_dly[k-1];
  end

  // |u|^2 and the equilibrium polynomial
  always_ff @(posedge clk) begin
    usq1 <= sat_add(xx, yy);
    zz7  <= zz;
    usq  <= sat_add(usq1, zz7);
    p1   <= sat_add(ONE_S, ea);
    p2   <= sat_add(p1_dly[P1_DLY-1], eeb);
    ua14 <= ua;
    poly <= sat_sub(p2, ua14);
  end

  // weight: g*2/9, g/9 or g/72 (zero for an unused direction), truncated toward zero
  logic [IW-1:0] g_mag, div_x, q9, mag;
  logic [3:0]    rem9;
  logic          neg_dly [S_W1:S_Q];
  logic          neg_mag;

  assign g_mag = g[IW-1] ? IW'(-g) : IW'(g);

  always_ff @(posedge clk) begin
    div_x <= (info_g.cls == CLS_DIAG) ? (g_mag >> 3) : g_mag;
    neg_dly[S_W1] <= g[IW-1];
    for (int k = S_W1 + 1; k <= S_Q; k++) neg_dly[k] <= neg_dly[k-1];
  end

  lbmcol_div9 u_div9 (.clk(clk), .x(div_x), .q(q9), .rem(rem9));

  always_ff @(posedge clk) begin
    unique case (info_q.cls)
      CLS_REST: mag <= {q9[IW-2:0], 1'b0} + IW'(rem9 >= 4'd5);
      CLS_AXIS: mag <= q9;
      CLS_DIAG: mag <= q9;
      CLS_NONE: mag <= '0;
    endcase
    neg_mag <= neg_dly[S_Q];
  end

  // relaxation plus equilibrium, clamped to the port width
  logic signed [IW:0] fsum;
  acc_t               ft_m;

  assign ft_m = ft_dly[FT_DLY-1];
  assign fsum = neg_mag ? $signed({ft_m[IW-1], ft_m} - {1'b0, mag})
                        : $signed({ft_m[IW-1], ft_m} + {1'b0, mag});

  always_ff @(posedge clk) begin
    if (fsum > OUT_MAX) dist_out <= OUT_MAX[VALUE_WIDTH-1:0];
    else if (fsum < OUT_MIN) dist_out <= OUT_MIN[VALUE_WIDTH-1:0];
    else dist_out <= fsum[VALUE_WIDTH-1:0];
    out_direction <= d_pipe[S_MAG];
  end

`ifndef SYNTH
  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, S_OUT))
    else $error("result without a matching request");

  a_direction_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> out_direction == $past(direction, S_OUT))
    else $error("direction not carried with its request");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for lbm_d3q15_bgk_collision_core: D3Q15 BGK relaxation of one value.
// A scoreboard class predicts each relaxed value in 64-bit fixed point and checks results in order.
// Depends on lbmcol_pkg and the core RTL.
module testbench
  import lbmcol_pkg::*;
();

  typedef logic signed [63:0] q64_t;

  typedef struct packed {
    logic [31:0] dist_val;
    logic [3:0]  dir;
  } relaxed_t;

  localparam int          FRAC        = 28;
  localparam q64_t        Q64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q64_t        Q64_MIN     = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam q64_t        OUT_MAX     = 64'sd2147483647;
  localparam q64_t        OUT_MIN     = -64'sd2147483648;
  localparam q64_t        Q_ONE       = 64'sd268435456;
  localparam logic [31:0] V_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN       = 32'h8000_0000;
  localparam logic [31:0] V_ONE       = 32'h1000_0000;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 40;
  localparam int          MAX_PRINTS  = 20;

  class collision_scoreboard;
    logic [30:0] relax_rate;
    logic [30:0] inv_cs2;
    logic [30:0] inv_2cs4;
    relaxed_t    pending_relaxed[$];
    int          mismatches;
    int          results_checked;

    function new();
      relax_rate      = 31'h1000_0000;
      inv_cs2         = 31'h3000_0000;
      inv_2cs4        = 31'h4800_0000;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void set_register(input logic [1:0] idx, input logic [30:0] val);
      case (idx)
        REG_RELAX:    relax_rate = val;
        REG_INV_CS2:  inv_cs2 = val;
        REG_INV_2CS4: inv_2cs4 = val;
        default: ;
      endcase
    endfunction

    function q64_t add_sat(input q64_t a, input q64_t b);
      logic signed [64:0] s;
      s = a + b;
      if (s > Q64_MAX) return Q64_MAX;
      if (s < Q64_MIN) return Q64_MIN;
      return s[63:0];
    endfunction

    function q64_t sub_sat(input q64_t a, input q64_t b);
      logic signed [64:0] s;
      s = a - b;
      if (s > Q64_MAX) return Q64_MAX;
      if (s < Q64_MIN) return Q64_MIN;
      return s[63:0];
    endfunction

    // a*b / 2^sh, round half away from zero, saturated
    function q64_t mul_round(input q64_t a, input q64_t b, input int unsigned sh);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] p;
      ma = a[63] ? ~a + 64'd1 : a;
      mb = b[63] ? ~b + 64'd1 : b;
      p = {64'd0, ma} * {64'd0, mb};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (a[63] ^ b[63]) begin
        if (p > {64'd0, 64'h8000_0000_0000_0000}) return Q64_MIN;
        return -p[63:0];
      end
      if (p > {64'd0, 64'h7FFF_FFFF_FFFF_FFFF}) return Q64_MAX;
      return p[63:0];
    endfunction

    function q64_t signed_term(input q64_t acc, input int s, input q64_t u);
      if (s > 0) return add_sat(acc, u);
      if (s < 0) return sub_sat(acc, u);
      return acc;
    endfunction

    // lattice vector signs and weight num/den; unused code gets zero weight
    function void lattice_vector(input logic [3:0] dir, output int sx, output int sy,
                                 output int sz, output int unsigned num,
                                 output int unsigned den);
      sx = 0; sy = 0; sz = 0; num = 1; den = 72;
      case (dir)
        DIR_REST: begin num = 2; den = 9; end
        DIR_PX:   begin sx = 1; den = 9; end
        DIR_NX:   begin sx = -1; den = 9; end
        DIR_PY:   begin sy = 1; den = 9; end
        DIR_NY:   begin sy = -1; den = 9; end
        DIR_PZ:   begin sz = 1; den = 9; end
        DIR_NZ:   begin sz = -1; den = 9; end
        DIR_PPP:  begin sx = 1; sy = 1; sz = 1; end
        DIR_NNN:  begin sx = -1; sy = -1; sz = -1; end
        DIR_PPN:  begin sx = 1; sy = 1; sz = -1; end
        DIR_NNP:  begin sx = -1; sy = -1; sz = 1; end
        DIR_PNP:  begin sx = 1; sy = -1; sz = 1; end
        DIR_NPN:  begin sx = -1; sy = 1; sz = -1; end
        DIR_NPP:  begin sx = -1; sy = 1; sz = 1; end
        DIR_PNN:  begin sx = 1; sy = -1; sz = -1; end
        default:  begin num = 0; den = 1; end
      endcase
    endfunction

    function q64_t apply_weight(input q64_t g, input int unsigned num,
                                input int unsigned den);
      logic [63:0] m;
      logic [63:0] q;
      m = g[63] ? ~g + 64'd1 : g;
      q = (m / den) * num + ((m % den) * num) / den;
      return g[63] ? ~q + 64'd1 : q;
    endfunction

    function relaxed_t relax_value(input logic signed [31:0] rho_in, ux_in, uy_in, uz_in,
                                   input logic [3:0] dir, input logic signed [31:0] f_in);
      q64_t        rho, ux, uy, uz, f, r, ca, cb;
      q64_t        eu, usq, poly, g, feq, res;
      int          sx, sy, sz;
      int unsigned num, den;
      relaxed_t    out;
      rho = rho_in; ux = ux_in; uy = uy_in; uz = uz_in; f = f_in;
      r  = {33'd0, relax_rate};
      ca = {33'd0, inv_cs2};
      cb = {33'd0, inv_2cs4};
      lattice_vector(dir, sx, sy, sz, num, den);
      eu = signed_term(64'sd0, sx, ux);
      eu = signed_term(eu, sy, uy);
      eu = signed_term(eu, sz, uz);
      usq = add_sat(add_sat(mul_round(ux, ux, FRAC), mul_round(uy, uy, FRAC)),
                    mul_round(uz, uz, FRAC));
      poly = add_sat(Q_ONE, mul_round(eu, ca, FRAC));
      poly = add_sat(poly, mul_round(mul_round(eu, eu, FRAC), cb, FRAC));
      poly = sub_sat(poly, mul_round(usq, ca, FRAC + 1));
      g = mul_round(mul_round(rho, r, FRAC), poly, FRAC);
      feq = apply_weight(g, num, den);
      res = add_sat(mul_round(Q_ONE - r, f, FRAC), feq);
      if (res > OUT_MAX) res = OUT_MAX;
      if (res < OUT_MIN) res = OUT_MIN;
      out.dist_val = res[31:0];
      out.dir      = dir;
      return out;
    endfunction

    function void note_request(input logic [31:0] rho, ux, uy, uz, input logic [3:0] dir,
                               input logic [31:0] f);
      pending_relaxed.push_back(relax_value(rho, ux, uy, uz, dir, f));
    endfunction

    task report_mismatch(input string what);
      if (mismatches < MAX_PRINTS) $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(input logic [31:0] dist_val, input logic [3:0] dir);
      relaxed_t exp_r;
      if (pending_relaxed.size() == 0) begin
        report_mismatch($sformatf("result dist=%h dir=%0d with no request waiting",
                                  dist_val, dir));
        return;
      end
      exp_r = pending_relaxed.pop_front();
      results_checked++;
      if (dist_val !== exp_r.dist_val)
        report_mismatch($sformatf("result %0d dist_out got %h expected %h",
                                  results_checked, dist_val, exp_r.dist_val));
      if (dir !== exp_r.dir)
        report_mismatch($sformatf("result %0d out_direction got %0d expected %0d",
                                  results_checked, dir, exp_r.dir));
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic signed [31:0]  cell_density = '0;
  logic signed [31:0]  vel_x = '0;
  logic signed [31:0]  vel_y = '0;
  logic signed [31:0]  vel_z = '0;
  logic [3:0]          direction = '0;
  logic signed [31:0]  dist_in = '0;
  logic                wr_en = 1'b0;
  logic [1:0]          wr_index = '0;
  logic [30:0]         wr_data = '0;
  logic                done;
  logic signed [31:0]  dist_out;
  logic [3:0]          out_direction;

  collision_scoreboard sb;
  int                  requests_sent = 0;
  int                  settings_used = 1;
  int                  cycle_count = 0;
  bit                  burst = 1'b0;

  lbm_d3q15_bgk_collision_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cell_density(cell_density), .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .direction(direction), .dist_in(dist_in),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .dist_out(dist_out), .out_direction(out_direction)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending_relaxed.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(dist_out, out_direction);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // mostly near center, sometimes full range or an extreme
  function automatic logic [31:0] rand_value(input logic [31:0] center,
                                             input int unsigned span);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0: return V_MAX;
          1: return V_MIN;
          2: return 32'd0;
          3: return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
      default: return center + $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  task automatic send_request(input logic [31:0] rho, ux, uy, uz, input logic [3:0] dir,
                              input logic [31:0] f);
    int unsigned gap;
    start <= 1'b1;
    cell_density <= rho;
    vel_x <= ux;
    vel_y <= uy;
    vel_z <= uz;
    direction <= dir;
    dist_in <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rho, ux, uy, uz, dir, f);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (sb.pending_relaxed.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [30:0] rate, input logic [30:0] cs2,
                             input logic [30:0] cs4);
    logic [30:0] junk;
    junk = 31'($urandom());
    wr_en <= 1'b1;
    wr_index <= REG_RELAX;
    wr_data <= rate;
    @(posedge clk);
    wr_index <= REG_INV_CS2;
    wr_data <= cs2;
    @(posedge clk);
    wr_index <= REG_INV_2CS4;
    wr_data <= cs4;
    @(posedge clk);
    wr_index <= REG_UNUSED;
    wr_data <= junk;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_register(REG_RELAX, rate);
    sb.set_register(REG_INV_CS2, cs2);
    sb.set_register(REG_INV_2CS4, cs4);
    sb.set_register(REG_UNUSED, junk);
    settings_used++;
  endtask

  task automatic run_random(input int count);
    logic [3:0] dir;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      dir = ($urandom_range(0, 19) == 0) ? DIR_NONE : 4'($urandom_range(0, 14));
      send_request(rand_value(V_ONE, 32'h0400_0000), rand_value(32'd0, 32'h0200_0000),
                   rand_value(32'd0, 32'h0200_0000), rand_value(32'd0, 32'h0200_0000),
                   dir, rand_value(32'h01C7_1C72, 32'h0200_0000));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every direction at reset settings, small velocity, f near 1/9
    for (int d = 0; d < 16; d++)
      send_request(V_ONE, 32'h00CC_CCCD, 32'hFF85_1EB8, 32'h0051_EB85, 4'(d), 32'h01C7_1C72);
    // field extremes and saturation
    send_request(V_MAX, V_MAX, V_MAX, V_MAX, DIR_PPP, V_MAX);
    send_request(V_MIN, V_MIN, V_MIN, V_MIN, DIR_NNN, V_MIN);
    send_request(V_MAX, V_MIN, V_MAX, V_MIN, DIR_PNP, V_MIN);
    send_request(V_MIN, V_MAX, V_MIN, V_MAX, DIR_PX, V_MAX);
    send_request(32'd0, 32'd0, 32'd0, 32'd0, DIR_REST, 32'd0);
    send_request(V_ONE, V_MIN, 32'd0, 32'd0, DIR_NX, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DIR_NONE,
                 32'hFFFF_FFFF);
    drain_pipeline();

    load_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    run_random(200);
    drain_pipeline();
    load_config(31'd0, 31'd0, 31'h7FFF_FFFF);
    run_random(200);
    drain_pipeline();
    load_config(31'h1CCC_CCCD, 31'h3000_0000, 31'h4800_0000);
    run_random(200);
    drain_pipeline();
    load_config(31'($urandom()), 31'($urandom()), 31'($urandom()));
    run_random(200);
    drain_pipeline();
    load_config(31'h0999_999A, 31'h3000_0000, 31'h4800_0000);
    run_random(200);
    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests under %0d register settings (rate zero, one, above one, max).",
             requests_sent, settings_used);
    $display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_relaxed.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
